[rtl/core/vcm_pkg.sv]
// Package for the vector clock merge and compare block.
// Holds the request and result structs, the op codes and the controller interface types.
// Has no dependencies; every other file in rtl/core uses it.
package vcm_pkg;

	localparam logic [2:0] OP_MERGE   = 3'd0;
	localparam logic [2:0] OP_PRED    = 3'd1;
	localparam logic [2:0] OP_COMPARE = 3'd2;
	localparam logic [2:0] OP_INC     = 3'd3;
	localparam logic [2:0] OP_DEC     = 3'd4;

	localparam int unsigned VAL_W    = 32;
	localparam int unsigned THREAD_W = 6;

	typedef struct packed {
		logic [2:0]          op;
		logic [THREAD_W-1:0] thread;
		logic [VAL_W-1:0]    other_value;
		logic                sender_owner;
		logic                last;
	} in_t;

	typedef struct packed {
		logic             changed;
		logic             less_equal;
		logic             less_than;
		logic [VAL_W-1:0] owner_value;
	} out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic has_result;
	} sts_t;

endpackage

[rtl/core/vcm_ctrl.sv]
// Controller for the vector clock merge and compare block.
// Sequences capture and commit of one request and owns the output valid flag.
// Depends on vcm_pkg.
module vcm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  vcm_pkg::sts_t sts,
	output vcm_pkg::cmd_t cmd
);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.capture = in_valid && in_ready;
	// A request with a result commits only when the output register has room.
	assign cmd.commit  = (state_q == S_EXEC) &&
		(!sts.has_result || !out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.capture) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cmd.commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.commit && sts.has_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !in_ready)
		else $error("request accepted while another is in progress");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && sts.has_result) |=> out_valid)
		else $error("committed result not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && sts.has_result && out_valid_q && !out_ready) |-> !cmd.commit)
		else $error("pending result overwritten");
`endif

endmodule

[rtl/core/vcm_datapath.sv]
// Datapath for the vector clock merge and compare block.
// Holds the clock store, owner register, flag accumulators and the output register.
// Depends on vcm_pkg.
module vcm_datapath #(
	parameter int unsigned THREADS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vcm_pkg::in_t                 in_data,
	input  logic                         cfg_we,
	input  logic [vcm_pkg::THREAD_W-1:0] cfg_wdata,
	input  vcm_pkg::cmd_t                cmd,
	output vcm_pkg::sts_t                sts,
	output vcm_pkg::out_t                out_data
);

	// Only 64 threads can be addressed, so the store never needs more rows.
	localparam int unsigned ADDRESSABLE = 1 << vcm_pkg::THREAD_W;
	localparam int unsigned DEPTH       = (THREADS < ADDRESSABLE) ? THREADS : ADDRESSABLE;
	localparam int unsigned AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW          = $clog2(THREADS + 1) + 1;
	localparam int unsigned XW          = (CW > vcm_pkg::THREAD_W) ? CW : vcm_pkg::THREAD_W;
	localparam logic [XW-1:0] THREADS_X = XW'(THREADS);
	localparam logic [vcm_pkg::VAL_W-1:0] VAL_MAX = '1;

	logic [vcm_pkg::VAL_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]          vld_q;

	logic [vcm_pkg::THREAD_W-1:0] owner_q;
	logic                         changed_acc_q;
	logic                         le_acc_q;
	logic                         lt_acc_q;

	logic [2:0]                op_q;
	logic [vcm_pkg::VAL_W-1:0] ov_q;
	logic                      so_q;
	logic                      last_q;
	logic                      inrange_q;
	logic [AW-1:0]             addr_q;
	logic [vcm_pkg::VAL_W-1:0] rd_q;
	logic                      rd_vld_q;

	logic [vcm_pkg::THREAD_W-1:0] sel;
	logic                         sel_inrange;
	logic [vcm_pkg::VAL_W-1:0]    cur;
	logic [vcm_pkg::VAL_W-1:0]    ov_adj;
	logic [vcm_pkg::VAL_W-1:0]    wdata;
	logic                         we;
	logic                         raise;
	logic                         gt;
	logic                         lt;
	logic                         le_n;
	logic                         lt_n;
	logic                         chg_n;
	vcm_pkg::out_t                res;

	// Increment and decrement address the owner entry, everything else the carried thread.
	assign sel = (in_data.op == vcm_pkg::OP_INC || in_data.op == vcm_pkg::OP_DEC) ?
		owner_q : in_data.thread;
	assign sel_inrange = XW'(sel) < THREADS_X;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= in_data.op;
			ov_q      <= in_data.other_value;
			so_q      <= in_data.sender_owner;
			last_q    <= in_data.last;
			inrange_q <= sel_inrange;
			addr_q    <= sel[AW-1:0];
			rd_q      <= mem[sel[AW-1:0]];
		end
		if (we) mem[addr_q] <= wdata;
	end

	// Valid bits make never-written rows read as zero after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.capture) rd_vld_q <= vld_q[sel[AW-1:0]];
			if (we) vld_q[addr_q] <= 1'b1;
		end
	end

	assign cur    = rd_vld_q ? rd_q : '0;
	assign ov_adj = (op_q == vcm_pkg::OP_PRED && so_q && ov_q != '0) ? ov_q - 1'b1 : ov_q;
	assign raise  = inrange_q && (cur < ov_adj);
	assign gt     = inrange_q && (cur > ov_q);
	assign lt     = inrange_q && (cur < ov_q);
	assign chg_n  = changed_acc_q | raise;
	assign le_n   = le_acc_q & ~gt;
	assign lt_n   = lt_acc_q | lt;

	always_comb begin
		wdata          = ov_adj;
		we             = 1'b0;
		res            = '0;
		sts.has_result = 1'b0;
		case (op_q)
			vcm_pkg::OP_MERGE, vcm_pkg::OP_PRED: begin
				we             = cmd.commit && raise;
				res.changed    = chg_n;
				sts.has_result = last_q;
			end
			vcm_pkg::OP_COMPARE: begin
				res.less_equal = le_n;
				res.less_than  = le_n & lt_n;
				sts.has_result = last_q;
			end
			vcm_pkg::OP_INC, vcm_pkg::OP_DEC: begin
				if (op_q == vcm_pkg::OP_INC) begin
					wdata = (cur != VAL_MAX) ? cur + 1'b1 : cur;
				end else begin
					wdata = (cur != '0) ? cur - 1'b1 : cur;
				end
				we              = cmd.commit && inrange_q;
				res.owner_value = inrange_q ? wdata : '0;
				sts.has_result  = 1'b1;
			end
			default: begin
				sts.has_result = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q       <= '0;
			changed_acc_q <= 1'b0;
			le_acc_q      <= 1'b1;
			lt_acc_q      <= 1'b0;
		end else begin
			if (cfg_we) owner_q <= cfg_wdata;
			if (cmd.commit) begin
				if (op_q == vcm_pkg::OP_MERGE || op_q == vcm_pkg::OP_PRED) begin
					changed_acc_q <= last_q ? 1'b0 : chg_n;
				end
				if (op_q == vcm_pkg::OP_COMPARE) begin
					le_acc_q <= last_q ? 1'b1 : le_n;
					lt_acc_q <= last_q ? 1'b0 : lt_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && sts.has_result) out_data <= res;
	end

endmodule

[rtl/core/vector_clock_merge_compare.sv]
// Top level of the vector clock merge and compare block.
// Joins the controller and the datapath; depends on vcm_pkg, vcm_ctrl and vcm_datapath.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    vcm_pkg::in_t
//   out      output     out_valid / out_ready  vcm_pkg::out_t
//   cfg      input      cfg_we                 owner thread, 6 bits
//
// Each request is captured, and its store row read, in the idle state; the execute state
// updates the row if the op writes it and loads the result into the output register.
// The output register holds one finished result; a new request is accepted while it waits.
// A request with a result waits in the execute state while a held result is not yet taken.
// Reset is asynchronous; the store reads as zero afterwards through per-row valid bits.
module vector_clock_merge_compare #(
	parameter int unsigned THREADS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  vcm_pkg::in_t                 in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output vcm_pkg::out_t                out_data,
	input  logic                         cfg_we,
	input  logic [vcm_pkg::THREAD_W-1:0] cfg_wdata
);

	vcm_pkg::cmd_t cmd;
	vcm_pkg::sts_t sts;

	vcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	vcm_datapath #(
		.THREADS (THREADS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule
